// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, command codes, status codes and word types of the deque unit.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH      = 64;               // power of two: ring pointers wrap
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   localparam int OPCODE_W   = 3;
   localparam int STATUS_W   = 2;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

   // Result FIFO at the output
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

   // Opcodes on the request channel
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DROP_FRONT = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DROP_BACK  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ_OUT   = 3'd5;

   // Status codes on the response channel
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT,
      KIND_PUSH_BACK,
      KIND_DROP_FRONT,
      KIND_DROP_BACK,
      KIND_CLEAR,
      KIND_READ_OUT,
      KIND_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [DATA_WIDTH-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                has_value;
      logic                last;
      logic [CNT_W-1:0]    occupancy;
      logic [STATUS_W-1:0] status;
   } rsp_meta_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      rsp_meta_type          meta;
   } rsp_word_type;

endpackage

// ----- rtl/dq_req_if.sv -----
// ----------------------------------------------------------------------------
// dq_req_if
// Command channel: valid/ready plus opcode and pushed value.
// ----------------------------------------------------------------------------
interface dq_req_if import dq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OPCODE_W-1:0]          opcode;
   logic signed [DATA_WIDTH-1:0] value_in;

   modport source (output valid, output opcode, output value_in, input ready);
   modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

// ----- rtl/dq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dq_rsp_if
// Result channel: valid/ready plus element value, flags, size and status.
// ----------------------------------------------------------------------------
interface dq_rsp_if import dq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value_out;
   logic                         has_value;
   logic                         last;
   logic [CNT_W-1:0]             occupancy;
   logic [STATUS_W-1:0]          status;

   modport source (output valid, output value_out, output has_value, output last,
                   output occupancy, output status, input ready);
   modport sink   (input valid, input value_out, input has_value, input last,
                   input occupancy, input status, output ready);
endinterface

// ----- rtl/dq_front.sv -----
// ----------------------------------------------------------------------------
// dq_front
// Accepts command words, decodes the opcode and holds them in a short queue.
// ----------------------------------------------------------------------------
module dq_front import dq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_chan,
   output logic      cmd_valid,
   output cmd_type   cmd,
   input  logic      cmd_pop
);

   cmd_type                q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  qcnt_ff, qcnt_in;
   logic                   push;
   cmd_type                decoded;

   assign req_chan.ready = (qcnt_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (qcnt_ff != '0);
   assign cmd            = q_ff[rd_ptr_ff];

   always_comb begin
      decoded.value = req_chan.value_in;
      case (req_chan.opcode)
         OP_PUSH_FRONT: decoded.kind = KIND_PUSH_FRONT;
         OP_PUSH_BACK:  decoded.kind = KIND_PUSH_BACK;
         OP_DROP_FRONT: decoded.kind = KIND_DROP_FRONT;
         OP_DROP_BACK:  decoded.kind = KIND_DROP_BACK;
         OP_CLEAR:      decoded.kind = KIND_CLEAR;
         OP_READ_OUT:   decoded.kind = KIND_READ_OUT;
         default:       decoded.kind = KIND_NOP;   // unused opcodes
      endcase
   end

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, cmd_pop})
         2'b10:   qcnt_in = qcnt_ff + 1'b1;
         2'b01:   qcnt_in = qcnt_ff - 1'b1;
         default: qcnt_in = qcnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcnt_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcnt_ff   <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- rtl/dq_back.sv -----
// ----------------------------------------------------------------------------
// dq_back
// Executes commands against the ring store and queues result words.
// ----------------------------------------------------------------------------
module dq_back import dq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   dq_rsp_if.source  rsp_chan
);

   // Ring store
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] mem_q_ff;
   logic                  we, re;
   logic [PTR_W-1:0]      waddr, raddr;

   // Deque state
   logic [PTR_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_active_ff, rd_active_in;
   logic [CNT_W-1:0]      rd_pos_ff, rd_pos_in;

   // Result stage aligned with the memory read
   logic                  p1_valid_ff, p1_valid_in;
   rsp_meta_type          p1_meta_ff, p1_meta_in;

   // Output FIFO
   rsp_word_type          oq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] owr_ff, ord_ff;
   logic [OUTQ_CNT_W-1:0] ocnt_ff;
   logic                  opop;
   rsp_word_type          oword, ohead;

   logic                  space, full, empty, rd_last;

   // Room for the word in flight plus the one issued now
   assign space = ({1'b0, ocnt_ff} + (OUTQ_CNT_W + 1)'(p1_valid_ff))
                  < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_last = ((rd_pos_ff + 1'b1) == cnt_ff);

   always_comb begin
      front_in     = front_ff;
      cnt_in       = cnt_ff;
      rd_active_in = rd_active_ff;
      rd_pos_in    = rd_pos_ff;
      p1_valid_in  = 1'b0;
      p1_meta_in   = '{has_value: 1'b0, last: 1'b1, occupancy: cnt_ff, status: ST_OK};
      cmd_pop      = 1'b0;
      we           = 1'b0;
      waddr        = front_ff;
      re           = 1'b0;
      raddr        = front_ff + rd_pos_ff[PTR_W-1:0];

      if (space) begin
         if (rd_active_ff) begin
            re                   = 1'b1;
            p1_valid_in          = 1'b1;
            p1_meta_in.has_value = 1'b1;
            p1_meta_in.last      = rd_last;
            rd_pos_in            = rd_pos_ff + 1'b1;
            if (rd_last) begin
               rd_active_in = 1'b0;
            end
         end else if (cmd_valid) begin
            cmd_pop     = 1'b1;
            p1_valid_in = 1'b1;
            case (cmd.kind)
               KIND_PUSH_FRONT: begin
                  if (full) begin
                     p1_meta_in.status = ST_FULL;
                  end else begin
                     front_in = front_ff - 1'b1;
                     we       = 1'b1;
                     waddr    = front_ff - 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                  end
               end
               KIND_PUSH_BACK: begin
                  if (full) begin
                     p1_meta_in.status = ST_FULL;
                  end else begin
                     we     = 1'b1;
                     waddr  = front_ff + cnt_ff[PTR_W-1:0];
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               KIND_DROP_FRONT: begin
                  if (empty) begin
                     p1_meta_in.status = ST_EMPTY;
                  end else begin
                     front_in = front_ff + 1'b1;
                     cnt_in   = cnt_ff - 1'b1;
                  end
               end
               KIND_DROP_BACK: begin
                  if (empty) begin
                     p1_meta_in.status = ST_EMPTY;
                  end else begin
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
               KIND_CLEAR: begin
                  cnt_in   = '0;
                  front_in = '0;
               end
               KIND_READ_OUT: begin
                  if (!empty) begin
                     // no word for the command itself; the read-out sequencer issues the element words
                     p1_valid_in  = 1'b0;
                     rd_active_in = 1'b1;
                     rd_pos_in    = '0;
                  end
               end
               default: begin
               end
            endcase
            p1_meta_in.occupancy = cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         cnt_ff       <= '0;
         rd_active_ff <= 1'b0;
         rd_pos_ff    <= '0;
         p1_valid_ff  <= 1'b0;
      end else begin
         front_ff     <= front_in;
         cnt_ff       <= cnt_in;
         rd_active_ff <= rd_active_in;
         rd_pos_ff    <= rd_pos_in;
         p1_valid_ff  <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_meta_ff <= p1_meta_in;
      if (we) begin
         mem[waddr] <= cmd.value;
      end
      if (re) begin
         mem_q_ff <= mem[raddr];
      end
   end

   // Output FIFO
   assign oword.value = p1_meta_ff.has_value ? mem_q_ff : '0;
   assign oword.meta  = p1_meta_ff;
   assign ohead       = oq_ff[ord_ff];
   assign opop        = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid     = (ocnt_ff != '0);
   assign rsp_chan.value_out = ohead.value;
   assign rsp_chan.has_value = ohead.meta.has_value;
   assign rsp_chan.last      = ohead.meta.last;
   assign rsp_chan.occupancy = ohead.meta.occupancy;
   assign rsp_chan.status    = ohead.meta.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (p1_valid_ff) begin
            owr_ff <= owr_ff + 1'b1;
         end
         if (opop) begin
            ord_ff <= ord_ff + 1'b1;
         end
         case ({p1_valid_ff, opop})
            2'b10:   ocnt_ff <= ocnt_ff + 1'b1;
            2'b01:   ocnt_ff <= ocnt_ff - 1'b1;
            default: ocnt_ff <= ocnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         oq_ff[owr_ff] <= oword;
      end
   end

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (ocnt_ff != OUTQ_CNT_W'(OUTQ_DEPTH)))
      else $error("result word issued with output FIFO full");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      rd_active_ff |-> !empty)
      else $error("read-out running on empty store");

   a_read_frozen: assert property (@(posedge clock) disable iff (reset)
      (rd_active_ff && $past(rd_active_ff)) |-> ($stable(cnt_ff) && $stable(front_ff)))
      else $error("store pointers moved during read-out");

   a_pop_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && !rd_active_ff))
      else $error("command popped while busy or absent");

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words in a ring store: push/drop at either end,
// clear, and full read-out from front to back.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake            payload
//   req_chan  in    valid/ready          opcode, value_in
//   rsp_chan  out   valid/ready          value_out, has_value, last,
//                                        occupancy, status
//
// Push, drop, clear and no-op commands each yield one result word in the back end,
// so they sustain one word per cycle while the result FIFO has room.
// A read-out of N elements occupies the back end for a decode step, then one
// store read per element through the single read port.
// Results pass through the p1 result stage and the result FIFO to rsp_chan.
// Reset is synchronous; it empties the deque and both queues. Store contents
// are not cleared and need no clearing pass.
// A stalled rsp_chan fills the 4-word result FIFO, then the back end holds,
// then the 2-word command queue fills and req_chan.ready drops.
//
module double_ended_queue_unit import dq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_chan,
   dq_rsp_if.source  rsp_chan
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // Front end: accept and decode, buffer up to two commands
   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Back end: ring store, pointers, read-out sequencer, result FIFO
   dq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- tb/double_ended_queue_unit_tb.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Self-checking bench for the deque unit. A scripted opening covers the empty
// and full edges, both ends, clear, spare opcodes and read-out. Random
// push/drop/read-out bursts follow under three idle schedules. A behavioral
// deque predicts every response word, and responses are checked in order.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dq_pkg::*;

   // Spare opcodes: the unit treats them as no-ops that report the size
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS  = 100;
   localparam int STALL_LIMIT   = 5000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES = 20;    // results trail the back end through its result stage and FIFO

   // Idle schedule per phase: slow sink, then slow source, then full rate
   localparam int SOURCE_IDLE_PCT [3] = '{7, 85, 0};
   localparam int SINK_IDLE_PCT   [3] = '{85, 7, 0};

   // One response word as the predictor sees it
   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         has_value;
      logic                         last;
      logic [CNT_W-1:0]             occupancy;
      logic [STATUS_W-1:0]          status;
   } deque_word_type;

   // Scripted command. reps > 1 repeats the command with fresh random values.
   // typed rows carry the single status word expected, written out by hand.
   typedef struct packed {
      logic [OPCODE_W-1:0]          op;
      logic signed [DATA_WIDTH-1:0] value;
      logic [7:0]                   reps;
      logic                         typed;
      logic [STATUS_W-1:0]          status;
      logic [CNT_W-1:0]             occupancy;
   } script_row_type;

   localparam int SCRIPT_ROWS = 25;
   localparam script_row_type OPENING_SCRIPT [SCRIPT_ROWS] = '{
      // empty queue: read-out gives one bare word, drops are refused
      '{OP_READ_OUT,   32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd0},
      '{OP_DROP_FRONT, 32'h0000_0000,  8'd1, 1'b1, ST_EMPTY, 7'd0},
      '{OP_DROP_BACK,  32'h0000_0000,  8'd1, 1'b1, ST_EMPTY, 7'd0},
      // value extremes at both ends
      '{OP_PUSH_BACK,  32'h7FFF_FFFF,  8'd1, 1'b1, ST_OK,    7'd1},
      '{OP_PUSH_FRONT, 32'h8000_0000,  8'd1, 1'b1, ST_OK,    7'd2},
      '{OP_PUSH_BACK,  32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd3},
      '{OP_PUSH_FRONT, 32'hFFFF_FFFF,  8'd1, 1'b1, ST_OK,    7'd4},
      '{OP_READ_OUT,   32'h0000_0000,  8'd1, 1'b0, ST_OK,    7'd0},
      // spare opcodes leave the queue alone
      '{OP_SPARE_6,    32'hFFFF_FFFF,  8'd1, 1'b1, ST_OK,    7'd4},
      '{OP_SPARE_7,    32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd4},
      '{OP_DROP_FRONT, 32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd3},
      '{OP_DROP_BACK,  32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd2},
      '{OP_READ_OUT,   32'h0000_0000,  8'd1, 1'b0, ST_OK,    7'd0},
      '{OP_CLEAR,      32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd0},
      '{OP_READ_OUT,   32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd0},
      '{OP_PUSH_FRONT, 32'h5555_5555,  8'd1, 1'b1, ST_OK,    7'd1},
      '{OP_PUSH_BACK,  32'hAAAA_AAAA,  8'd1, 1'b1, ST_OK,    7'd2},
      '{OP_READ_OUT,   32'h0000_0000,  8'd1, 1'b0, ST_OK,    7'd0},
      '{OP_CLEAR,      32'h0000_0000,  8'd1, 1'b1, ST_OK,    7'd0},
      // fill from the front (head wraps below zero), then push into a full queue
      '{OP_PUSH_FRONT, 32'h0000_0000, 8'd64, 1'b0, ST_OK,    7'd0},
      '{OP_PUSH_BACK,  32'h1234_5678,  8'd1, 1'b1, ST_FULL,  7'd64},
      '{OP_PUSH_FRONT, 32'h8765_4321,  8'd1, 1'b1, ST_FULL,  7'd64},
      '{OP_READ_OUT,   32'h0000_0000,  8'd1, 1'b0, ST_OK,    7'd0},
      // drain from the front across the wrap, then drop from empty
      '{OP_DROP_FRONT, 32'h0000_0000, 8'd64, 1'b0, ST_OK,    7'd0},
      '{OP_DROP_BACK,  32'h0000_0000,  8'd1, 1'b1, ST_EMPTY, 7'd0}
   };

   logic clock = 1'b0;
   logic reset;

   dq_req_if req_chan ();
   dq_rsp_if rsp_chan ();

   double_ended_queue_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: its own ring, head and size
   logic signed [DATA_WIDTH-1:0] model_ring [DEPTH];
   logic [PTR_W-1:0]             model_head = '0;
   logic [CNT_W-1:0]             model_size = '0;

   deque_word_type pending_results [$];  // words still owed by the unit, oldest first
   script_row_type script_notes    [$];  // scripted rows in flight, one per command
   int          mismatch_count  = 0;
   int          stall_cycles    = 0;
   int          words_sent      = 0;
   int          source_idle_pct = SOURCE_IDLE_PCT[0];
   int          sink_idle_pct   = SINK_IDLE_PCT[0];

   // ---------------------------------------------------------------------
   // Predictor: applies one accepted command word, queues the words it owes
   // ---------------------------------------------------------------------
   function automatic void apply_command(input logic [OPCODE_W-1:0] op,
                                         input logic signed [DATA_WIDTH-1:0] val);
      deque_word_type   word;
      logic [PTR_W-1:0] slot;
      int               k;
      word = '{value: '0, has_value: 1'b0, last: 1'b1, occupancy: '0, status: ST_OK};
      case (op)
         OP_PUSH_FRONT: begin
            if (model_size == CNT_W'(DEPTH)) begin
               word.status = ST_FULL;
            end else begin
               model_head = model_head - 1'b1;   // ring wraps on the pointer width
               model_ring[model_head] = val;
               model_size++;
            end
         end
         OP_PUSH_BACK: begin
            if (model_size == CNT_W'(DEPTH)) begin
               word.status = ST_FULL;
            end else begin
               slot = model_head + model_size[PTR_W-1:0];
               model_ring[slot] = val;
               model_size++;
            end
         end
         OP_DROP_FRONT: begin
            if (model_size == 0) begin
               word.status = ST_EMPTY;
            end else begin
               model_head = model_head + 1'b1;
               model_size--;
            end
         end
         OP_DROP_BACK: begin
            if (model_size == 0) word.status = ST_EMPTY;
            else model_size--;
         end
         OP_CLEAR: begin
            model_size = '0;
            model_head = '0;
         end
         OP_READ_OUT: begin
            // one word per element, front first; empty queue falls through
            // to the single bare status word
            if (model_size != 0) begin
               for (k = 0; k < model_size; k++) begin
                  slot           = model_head + PTR_W'(k);
                  word.value     = model_ring[slot];
                  word.has_value = 1'b1;
                  word.last      = (k + 1 == model_size);
                  word.occupancy = model_size;
                  word.status    = ST_OK;
                  pending_results.push_back(word);
               end
               return;
            end
         end
         default: ;  // spare opcodes: no change
      endcase
      word.occupancy = model_size;
      pending_results.push_back(word);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
      mismatch_count++;
   endtask

   // Compare the response word on the bus with the oldest one owed
   task automatic check_result();
      deque_word_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected word", 64'(rsp_chan.value_out), 64'd0);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_chan.value_out !== want.value)
         report_mismatch("value_out", 64'(rsp_chan.value_out), 64'(want.value));
      if (rsp_chan.has_value !== want.has_value)
         report_mismatch("has_value", 64'(rsp_chan.has_value), 64'(want.has_value));
      if (rsp_chan.last !== want.last)
         report_mismatch("last", 64'(rsp_chan.last), 64'(want.last));
      if (rsp_chan.occupancy !== want.occupancy)
         report_mismatch("occupancy", 64'(rsp_chan.occupancy), 64'(want.occupancy));
      if (rsp_chan.status !== want.status)
         report_mismatch("status", 64'(rsp_chan.status), 64'(want.status));
   endtask

   // ---------------------------------------------------------------------
   // Monitor: both handshakes are sampled at the rising edge, before any
   // update scheduled at that edge lands.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      script_row_type note;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            apply_command(req_chan.opcode, req_chan.value_in);
            if (script_notes.size() != 0) begin
               note = script_notes.pop_front();
               // hand-written status word stands in for the predicted one
               if (note.typed)
                  pending_results[pending_results.size() - 1] =
                     '{value: '0, has_value: 1'b0, last: 1'b1,
                       occupancy: note.occupancy, status: note.status};
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // Sink side back-pressure, per the current idle schedule
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   // Watchdog: nothing moving on either channel for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Source side
   // ---------------------------------------------------------------------

   // Present one command word and hold it until the unit takes it
   task automatic send_word(input logic [OPCODE_W-1:0] op,
                            input logic signed [DATA_WIDTH-1:0] val);
      while ($urandom_range(0, 99) < source_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.value_in <= val;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   // Hold off the source until every owed word has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Value mix: sign and magnitude extremes now and then, else anything
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
         3:       return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_push();
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_drop();
      return $urandom_range(0, 1) ? OP_DROP_BACK : OP_DROP_FRONT;
   endfunction

   // One random burst. Most are well formed: a run of pushes, a few drops,
   // a read-out to expose the whole ring, sometimes a clear. Some are raw
   // opcode noise, and now and then the queue is driven past full.
   task automatic run_burst();
      int kind;
      kind = $urandom_range(0, 19);
      if ($urandom_range(0, 7) == 0) wait_for_results();
      if (kind < 13) begin
         repeat ($urandom_range(1, 8)) send_word(pick_push(), pick_value());
         repeat ($urandom_range(0, 4)) send_word(pick_drop(), pick_value());
         send_word(OP_READ_OUT, pick_value());
         if ($urandom_range(0, 3) == 0) send_word(OP_CLEAR, pick_value());
      end else if (kind < 19) begin
         repeat ($urandom_range(1, 6)) send_word(OPCODE_W'($urandom_range(0, 7)), pick_value());
      end else begin
         // overfill: the last pushes are refused as full
         send_word(OP_CLEAR, pick_value());
         repeat (DEPTH + 2) send_word(pick_push(), pick_value());
         send_word(OP_READ_OUT, pick_value());
         repeat ($urandom_range(1, 8)) send_word(pick_drop(), pick_value());
      end
   endtask

   initial begin
      int row;
      int phase;
      int first_random;
      script_row_type step;

      // every input known from time zero
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.opcode    = OP_CLEAR;
      req_chan.value_in  = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // scripted opening, under the first idle schedule
      for (row = 0; row < SCRIPT_ROWS; row++) begin
         step = OPENING_SCRIPT[row];
         repeat (step.reps) begin
            script_notes.push_back(step);
            send_word(step.op, (step.reps > 1) ? pick_value() : step.value);
         end
      end
      wait_for_results();

      // random bursts, one third of the budget per idle schedule
      first_random = words_sent;
      for (phase = 0; phase < 3; phase++) begin
         source_idle_pct = SOURCE_IDLE_PCT[phase];
         sink_idle_pct   = SINK_IDLE_PCT[phase];
         while (words_sent - first_random < RANDOM_ITEMS * (phase + 1) / 3) run_burst();
         wait_for_results();
      end

      // quiet tail: anything the unit still sends is an unexpected word
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dq_pkg.sv
rtl/dq_req_if.sv
rtl/dq_rsp_if.sv
rtl/dq_front.sv
rtl/dq_back.sv
rtl/double_ended_queue_unit.sv
tb/double_ended_queue_unit_tb.sv
